// ===== hw/rtl/sfm_pkg.sv =====
// Shared types and constants for the substring first-match search block.
// Used by sfm_front, sfm_engine, the top level and the testbench.
package sfm_pkg;

  localparam int MAX_PATTERN = 16;
  localparam int WIN_IDX_W   = $clog2(MAX_PATTERN);
  localparam int FILL_W      = WIN_IDX_W + 1;
  localparam int BYTE_W      = 8;
  localparam int POS_W       = 32;

  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = $clog2(QDEPTH);

  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 64;
  localparam int PAT_W       = MAX_PATTERN * BYTE_W;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_LEN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_HIGH = 2'd2;

  typedef struct packed {
    logic              end_of_text;
    logic [BYTE_W-1:0] text_byte;
  } sfm_item_t;

  typedef struct packed {
    logic [FILL_W-1:0] pattern_length;
    logic [PAT_W-1:0]  pattern;
  } sfm_cfg_t;

  typedef logic [MAX_PATTERN-1:0][BYTE_W-1:0] sfm_window_t;

  // Lay the pattern out in window order: window slot i (0 = newest byte)
  // must hold pattern byte len-1-i. Slots at or above len are don't-care.
  function automatic sfm_window_t align_pattern(input logic [PAT_W-1:0] pattern,
                                                input logic [FILL_W-1:0] len);
    sfm_window_t           res;
    logic [WIN_IDX_W-1:0]  idx;
    res = '0;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      idx    = WIN_IDX_W'(len - FILL_W'(1) - FILL_W'(i));
      res[i] = pattern[idx*BYTE_W +: BYTE_W];
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/sfm_front.sv =====
// Front end: accepts input beats, classifies them as text byte or end marker,
// and holds them in a short queue for the search engine. Depends on sfm_pkg.
module sfm_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [7:0]                s_tdata,   // [7:0] text_byte
  input  logic                      s_tlast,   // end_of_text
  output logic                      q_valid,
  output sfm_pkg::sfm_item_t        q_item,
  input  logic                      q_pop
);

  sfm_pkg::sfm_item_t              mem [sfm_pkg::QDEPTH];
  logic [sfm_pkg::QPTR_W-1:0]      wr_ptr;
  logic [sfm_pkg::QPTR_W-1:0]      rd_ptr;
  logic [sfm_pkg::QPTR_W:0]        count;
  sfm_pkg::sfm_item_t              in_item;
  logic                            push;
  logic                            pop;

  assign s_tready = (count != (sfm_pkg::QPTR_W+1)'(sfm_pkg::QDEPTH));
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (count != '0);
  assign pop      = q_pop && q_valid;
  assign q_item   = mem[rd_ptr];

  // Drop the data byte of an end marker so it never reaches the window
  always_comb begin
    in_item.end_of_text = s_tlast;
    in_item.text_byte   = s_tlast ? '0 : s_tdata[sfm_pkg::BYTE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hw/rtl/sfm_engine.sv =====
// Back end: sliding byte window, parallel pattern compare, position tracking
// and the result register. Depends on sfm_pkg.
module sfm_engine (
  input  logic                      clk,
  input  logic                      rst,
  input  sfm_pkg::sfm_cfg_t         cfg,
  input  logic                      q_valid,
  input  sfm_pkg::sfm_item_t        q_item,
  output logic                      q_pop,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [31:0]               m_tdata,   // [31:0] match_position
  output logic                      m_tuser    // found
);

  logic [sfm_pkg::BYTE_W-1:0]  recent [sfm_pkg::MAX_PATTERN];
  logic [sfm_pkg::FILL_W-1:0]  fill;
  logic [sfm_pkg::POS_W-1:0]   byte_index;
  logic                        reported;
  logic                        out_valid;
  logic                        out_found;
  logic [sfm_pkg::POS_W-1:0]   out_pos;

  logic [sfm_pkg::FILL_W-1:0]  len;
  logic [sfm_pkg::FILL_W-1:0]  fill_next;
  logic [sfm_pkg::POS_W-1:0]   byte_index_next;
  sfm_pkg::sfm_window_t        window;
  sfm_pkg::sfm_window_t        expect_win;
  logic [sfm_pkg::MAX_PATTERN-1:0] lane_ok;
  logic                        match;
  logic                        res_valid;
  logic                        res_found;
  logic [sfm_pkg::POS_W-1:0]   res_pos;
  logic                        is_end;
  logic                        shift_en;

  assign q_pop    = q_valid && (!out_valid || m_tready);
  assign is_end   = q_item.end_of_text;

  // Lengths above the window depth count as a full window
  assign len = (cfg.pattern_length > sfm_pkg::FILL_W'(sfm_pkg::MAX_PATTERN)) ?
               sfm_pkg::FILL_W'(sfm_pkg::MAX_PATTERN) : cfg.pattern_length;

  assign fill_next = (fill == sfm_pkg::FILL_W'(sfm_pkg::MAX_PATTERN)) ? fill : fill + 1'b1;
  assign byte_index_next = (byte_index == '1) ? byte_index : byte_index + 1'b1;
  assign expect_win = sfm_pkg::align_pattern(cfg.pattern, len);

  // Window as it stands after this byte: slot 0 newest
  always_comb begin
    window[0] = q_item.text_byte;
    for (int i = 1; i < sfm_pkg::MAX_PATTERN; i++) begin
      window[i] = recent[i-1];
    end
  end

  always_comb begin
    for (int i = 0; i < sfm_pkg::MAX_PATTERN; i++) begin
      lane_ok[i] = (window[i] == expect_win[i]) || (sfm_pkg::FILL_W'(i) >= len);
    end
  end

  assign match = (&lane_ok) && (fill_next >= len);

  always_comb begin
    res_valid = 1'b0;
    res_found = 1'b0;
    res_pos   = '0;
    shift_en  = 1'b0;
    if (is_end) begin
      if (!reported) begin
        res_valid = 1'b1;
        res_found = (len == '0);
        res_pos   = (len == '0) ? byte_index : '0;
      end
    end else if (!reported) begin
      if (len == '0) begin
        res_valid = 1'b1;
        res_found = 1'b1;
        res_pos   = byte_index;
      end else begin
        shift_en = 1'b1;
        if (match) begin
          res_valid = 1'b1;
          res_found = 1'b1;
          res_pos   = byte_index - sfm_pkg::POS_W'(len - 1'b1);
        end
      end
    end
  end

  // Window contents need no reset: only slots below the fill count are compared
  always_ff @(posedge clk) begin
    if (q_pop && shift_en) begin
      recent[0] <= q_item.text_byte;
      for (int i = 1; i < sfm_pkg::MAX_PATTERN; i++) begin
        recent[i] <= recent[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill       <= '0;
      byte_index <= '0;
      reported   <= 1'b0;
    end else if (q_pop) begin
      if (is_end) begin
        fill       <= '0;
        byte_index <= '0;
        reported   <= 1'b0;
      end else begin
        if (shift_en) begin
          fill       <= fill_next;
          byte_index <= byte_index_next;
        end
        if (res_valid) begin
          reported <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= res_valid;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && res_valid) begin
      out_found <= res_found;
      out_pos   <= res_pos;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_found;
  assign m_tdata  = out_pos;

endmodule

// ===== hw/rtl/substring_first_match_top.sv =====
// Top level of the substring first-match search: configuration registers,
// front queue and search engine. Depends on sfm_pkg, sfm_front, sfm_engine.
//
// Searches a byte stream for the first occurrence of a pattern of up to 16
// bytes. Each input beat carries one text byte in s_tdata; a beat with
// s_tlast high is the end marker of the text and its byte is ignored. The
// block takes one beat per clock cycle while its queue has room: the engine
// compares the whole 16-byte window against the pattern combinationally,
// and a four-entry queue in front of it keeps the input side moving while
// the output is stalled, until the queue fills. Each beat waits in the
// queue, and its result is held in a result register. A match gives
// m_tuser=1 with the zero-based start position in m_tdata; a text that ends
// without a match gives m_tuser=0 and position 0 at its end marker. Write
// the pattern registers only while the block is idle.
module substring_first_match_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // [7:0] text_byte
  input  logic        s_tlast,    // end_of_text
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,    // [31:0] match_position
  output logic        m_tuser,    // found
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  sfm_pkg::sfm_cfg_t   cfg;
  logic                q_valid;
  logic                q_pop;
  sfm_pkg::sfm_item_t  q_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        sfm_pkg::CFG_PAT_LEN:  cfg.pattern_length <= cfg_data[sfm_pkg::FILL_W-1:0];
        sfm_pkg::CFG_PAT_LOW:  cfg.pattern[sfm_pkg::CFG_DATA_W-1:0] <= cfg_data;
        sfm_pkg::CFG_PAT_HIGH: begin
          cfg.pattern[sfm_pkg::PAT_W-1:sfm_pkg::CFG_DATA_W] <= cfg_data;
        end
        default: cfg <= cfg;
      endcase
    end
  end

  sfm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  sfm_engine u_engine (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

// ===== hw/rtl/sfm_checker.sv =====
// Port-level checker for substring_first_match_top, attached by bind.
// Sees the top level's ports only; no package dependency.
module sfm_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tuser
);

  // Reset empties the result register
  a_out_empty_after_rst: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result beat valid right after reset");

  // Reset empties the queue, so input is open next cycle
  a_in_open_after_rst: assert property (@(posedge clk) rst |=> s_tready)
    else $error("input not ready right after reset");

  // A no-match result always reports position zero
  a_nomatch_pos_zero: assert property (@(posedge clk) disable iff (rst)
      m_tvalid && !m_tuser |-> m_tdata == 32'd0)
    else $error("no-match beat with nonzero position");

  // A stalled result beat holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
      m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result beat changed while stalled");

endmodule

bind substring_first_match_top sfm_checker u_sfm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// ===== bench/tb_substring_first_match_top.sv =====
`timescale 1ns / 1ps
// Testbench for substring_first_match_top: streams texts against changing patterns
// and checks each search result against a predictor kept in step with the block.
// Depends on sfm_pkg and the RTL of substring_first_match_top.
module tb_substring_first_match_top;
  import sfm_pkg::*;

  localparam int N_ITEMS     = 2000;
  localparam int QUIET_TAIL  = 300;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 8;

  typedef struct packed {
    logic        found;
    logic [31:0] pos;
  } match_report_t;

  // Tracks the search state and queues the reports the block owes us.
  class first_match_calc;
    logic [4:0]    pat_len;
    logic [127:0]  pat;
    logic [7:0]    recent [MAX_PATTERN];
    int unsigned   fill;
    logic [31:0]   next_pos;
    bit            reported;
    match_report_t expected_reports [$];
    int unsigned   errors;

    function new();
      pat_len = '0;
      pat     = '0;
      errors  = 0;
      clear_search();
    endfunction

    function void clear_search();
      foreach (recent[k]) recent[k] = '0;
      fill     = 0;
      next_pos = '0;
      reported = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [63:0] data);
      case (idx)
        CFG_PAT_LEN:  pat_len = data[4:0];
        CFG_PAT_LOW:  pat[63:0] = data;
        CFG_PAT_HIGH: pat[127:64] = data;
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return expected_reports.size();
    endfunction

    function void push_report(logic found, logic [31:0] pos);
      match_report_t r;
      r.found = found;
      r.pos   = pos;
      expected_reports.push_back(r);
    endfunction

    function void take_beat(logic [7:0] b, logic eot);
      int unsigned len;
      logic [31:0] cur;
      bit          hit;
      len = (pat_len > MAX_PATTERN) ? MAX_PATTERN : pat_len;
      cur = next_pos;
      if (eot) begin
        if (!reported) push_report(len == 0, (len == 0) ? cur : 32'd0);
        clear_search();
        return;
      end
      if (reported) return;
      // empty pattern matches at the current index without touching the window
      if (len == 0) begin
        reported = 1;
        push_report(1'b1, cur);
        return;
      end
      for (int k = MAX_PATTERN - 1; k > 0; k--) recent[k] = recent[k-1];
      recent[0] = b;
      if (fill < MAX_PATTERN) fill++;
      if (cur != '1) next_pos = cur + 1;
      if (fill < len) return;
      hit = 1;
      for (int k = 0; k < len; k++)
        if (recent[len-1-k] != pat[8*k +: 8]) hit = 0;
      if (!hit) return;
      reported = 1;
      push_report(1'b1, cur - (len - 1));
    endfunction

    function void check_report(logic found, logic [31:0] pos);
      match_report_t want;
      if (expected_reports.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual found=%0b position=%0d",
                 $time, found, pos);
        errors++;
        return;
      end
      want = expected_reports.pop_front();
      if (found !== want.found) begin
        $display("%0t: found mismatch, expected %0b, actual %0b", $time, want.found, found);
        errors++;
      end
      if (pos !== want.pos) begin
        $display("%0t: position mismatch, expected %0d, actual %0d", $time, want.pos, pos);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata   = '0;
  logic        s_tlast   = 1'b0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [31:0] m_tdata;
  logic        m_tuser;
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_index = CFG_PAT_LEN;
  logic [63:0] cfg_data  = '0;

  first_match_calc search = new();

  bit          tx_idle  = 1'b1;
  bit          rx_idle  = 1'b1;
  bit          hold_req = 1'b0;
  int unsigned n_sent   = 0;

  logic [7:0]  alpha [4];
  int unsigned alpha_n = 1;
  logic [7:0]  pat_bytes [MAX_PATTERN];
  int unsigned pat_use = 0;

  substring_first_match_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sample everything on the edge, before any of this step's updates land.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_we) search.write_reg(cfg_index, cfg_data);
      if (s_tvalid && s_tready) search.take_beat(s_tdata, s_tlast);
      if (m_tvalid && m_tready) search.check_report(m_tuser, m_tdata);
    end
  end

  initial begin : receiver
    @(posedge clk);
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (rx_idle && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    #(5_000_000);
    $display("simulation failed");
    $finish;
  end

  // Keep tvalid high into the next beat unless a gap follows.
  task automatic send_beat(input logic [7:0] b, input logic eot);
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= eot;
    do @(posedge clk); while (!s_tready);
    n_sent++;
    if (tx_idle && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  task automatic wait_idle(input int unsigned settle);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (search.pending() != 0) @(posedge clk);
    // beats that produce nothing may still be in flight
    repeat (settle) @(posedge clk);
  endtask

  task automatic load_pattern(input logic [4:0] len, input logic [63:0] lo,
                              input logic [63:0] hi);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_PAT_LEN;
    cfg_data  <= {59'd0, len};
    @(posedge clk);
    cfg_index <= CFG_PAT_LOW;
    cfg_data  <= lo;
    @(posedge clk);
    cfg_index <= CFG_PAT_HIGH;
    cfg_data  <= hi;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [7:0] filler(input bit wild);
    return wild ? 8'($urandom) : alpha[$urandom_range(0, alpha_n - 1)];
  endfunction

  task automatic load_random_pattern();
    int unsigned  pick;
    logic [4:0]   len;
    logic [127:0] packed_pat;
    bit           wild;
    pick = $urandom_range(0, 19);
    if (pick == 0)      len = 5'd0;
    else if (pick == 1) len = 5'(MAX_PATTERN);
    else if (pick == 2) len = 5'($urandom_range(17, 31));
    else                len = 5'($urandom_range(1, 8));
    pat_use = (len > MAX_PATTERN) ? MAX_PATTERN : len;
    alpha_n = $urandom_range(1, 4);
    foreach (alpha[k]) alpha[k] = 8'($urandom);
    wild = ($urandom_range(0, 4) == 0);
    foreach (pat_bytes[k]) begin
      pat_bytes[k] = wild ? 8'($urandom) : alpha[$urandom_range(0, alpha_n - 1)];
      packed_pat[8*k +: 8] = pat_bytes[k];
    end
    load_pattern(len, packed_pat[63:0], packed_pat[127:64]);
  endtask

  // Filler, then the pattern (intact, with one byte spoiled, or left out), filler, end marker.
  task automatic send_text();
    int unsigned mode;
    int unsigned lead;
    int unsigned tail;
    int unsigned flip;
    bit          wild;
    mode = $urandom_range(0, 9);
    wild = (mode == 8);
    lead = $urandom_range(0, 20);
    tail = $urandom_range(0, 8);
    flip = $urandom_range(0, (pat_use > 0) ? pat_use - 1 : 0);
    repeat (lead) send_beat(filler(wild), 1'b0);
    if (mode <= 7)
      for (int k = 0; k < pat_use; k++)
        send_beat((mode >= 6 && k == flip) ? pat_bytes[k] ^ 8'($urandom_range(1, 255))
                                           : pat_bytes[k], 1'b0);
    repeat (tail) send_beat(filler(wild), 1'b0);
    send_beat(8'($urandom), 1'b1);
  endtask

  initial begin : stimulus
    logic [127:0] dir_pat;
    bit           hold_done;
    bit           quiet_tail;
    hold_done = 1'b0;
    dir_pat   = {64'hFEDC_BA98_7654_3210, 64'h0123_4567_89AB_CDEF};
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // empty pattern after reset: first data byte and a bare end marker both report
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'h00, 1'b1);
    send_beat(8'hA5, 1'b1);
    wait_idle(SETTLE);

    // single zero byte: a miss, then a hit on a zero data byte
    load_pattern(5'd1, 64'h0, 64'h0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'h7E, 1'b1);
    send_beat(8'h5A, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'h00, 1'b1);
    wait_idle(SETTLE);

    // zero and all-ones pattern bytes; bytes after the match are dropped
    load_pattern(5'd3, 64'hFFFF_FFFF_FF00_FF00, 64'hFFFF_FFFF_FFFF_FFFF);
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'h81, 1'b0);
    send_beat(8'h00, 1'b1);
    wait_idle(SETTLE);

    // oversized length clamps to the full 16-byte window
    load_pattern(5'd31, dir_pat[63:0], dir_pat[127:64]);
    for (int k = 0; k < MAX_PATTERN; k++) send_beat(dir_pat[8*k +: 8], 1'b0);
    send_beat(8'hFF, 1'b1);

    while (n_sent < N_ITEMS) begin
      wait_idle(SETTLE);
      quiet_tail = (n_sent + QUIET_TAIL >= N_ITEMS);
      tx_idle    = !quiet_tail && ($urandom_range(0, 2) != 0);
      rx_idle    = !quiet_tail && ($urandom_range(0, 2) != 0);
      load_random_pattern();
      if (!hold_done && n_sent >= 600) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      repeat ($urandom_range(2, 6)) send_text();
      // leave a text open so the next pattern change lands mid-text
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 6)) send_beat(filler(1'b0), 1'b0);
    end
    wait_idle(20);

    if (search.errors == 0 && search.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
